[rtl/core/cpth_pkg.sv]
// Shared types and constants of the call profile table hotspot unit.
// No dependencies; imported by the top level.
package cpth_pkg;

	// field widths
	localparam int ADDR_W     = 64;
	localparam int OPS_W      = 32;
	localparam int CNT_W      = 64;
	localparam int MINC_W     = 32;
	localparam int LIM_W      = 7;
	localparam int SLOT_W     = 6;
	localparam int STATUS_W   = 3;
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	typedef logic [0:0] cfg_idx_t;
	localparam cfg_idx_t CFG_MIN_CALLS   = 1'b0;
	localparam cfg_idx_t CFG_ENTRY_LIMIT = 1'b1;

	localparam logic [MINC_W-1:0] MIN_CALLS_RST = 32'd100;
	localparam logic [LIM_W-1:0]  LIMIT_RST     = 7'd64;

	// result status codes
	typedef logic [STATUS_W-1:0] status_t;
	localparam status_t ST_EXISTING = 3'd0;
	localparam status_t ST_CREATED  = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_IGNORED  = 3'd3;
	localparam status_t ST_UNKNOWN  = 3'd4;

endpackage

[rtl/core/cpth_mul.sv]
// Iterative shift-add multiplier, one multiplier bit per cycle.
// Stand-alone; used by the top level for the hotspot test.
module cpth_mul #(
	parameter int AW = 64,
	parameter int BW = 7
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [AW-1:0]    a,
	input  logic [BW-1:0]    b,
	output logic             done,
	output logic [AW+BW-1:0] prod
);

	localparam int PW   = AW + BW;
	localparam int CNTW = $clog2(BW + 1);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] left_q;
	logic [PW-1:0]   mcand_q;
	logic [BW-1:0]   mplier_q;
	logic [PW-1:0]   acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			left_q   <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			acc_q    <= '0;
		end else begin
			// pulse done with the last partial product
			done_q <= !start && busy_q && (left_q == CNTW'(1));
			if (start) begin
				busy_q   <= 1'b1;
				left_q   <= CNTW'(BW);
				mcand_q  <= PW'(a);
				mplier_q <= b;
				acc_q    <= '0;
			end else if (busy_q) begin
				if (mplier_q[0])
					acc_q <= acc_q + mcand_q;
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
				left_q   <= left_q - 1'b1;
				if (left_q == CNTW'(1))
					busy_q <= 1'b0;
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

[rtl/core/call_profile_table_hotspot_unit.sv]
// Top level of the call profile table hotspot unit: key scan, table memories,
// update sequencer and result register. Depends on cpth_pkg and cpth_mul.
//
// Usage:
//   Requests enter on the s_axis group; s_axis_tuser is the event kind (0 call,
//   1 memory ops), s_axis_tdata carries the function address and op count.
//   Each request yields exactly one result on the m_axis group.
//   s_axis_tready is high only while the sequencer is idle; one request is in
//   work at a time. A request passes through the key scan, which reads the key
//   memory one entry per cycle, and, for a call that runs the hotspot test,
//   through the bit-serial multiplier, which steps through the UW bits of the
//   used count (7 for 64 entries). Zero addresses and memory events with a zero
//   op count skip the key scan. The result becomes valid in the same cycle as
//   the sequencer returns to idle and can take the next request.
//   The result waits in an output register; when the receiver stalls, the
//   sequencer holds its finished result until that register frees, and the
//   next request may be accepted as soon as the result is handed over.
//   Reset empties the table (used count zero), clears both totals and loads
//   min_total_calls = 100 and entry_limit = 64. No clearing pass is run:
//   entries at or above the used count are never read. The user must write the
//   configuration through cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module call_profile_table_hotspot_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// configuration write port
	input  logic                         cfg_we,
	input  cpth_pkg::cfg_idx_t           cfg_index,
	input  logic [cpth_pkg::CFG_DATA_W-1:0] cfg_data,
	// request stream
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [cpth_pkg::IN_DATA_W-1:0] s_axis_tdata,  // [63:0] func_address, [95:64] op_count
	input  logic                         s_axis_tuser,  // [0] kind
	// result stream
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [cpth_pkg::OUT_DATA_W-1:0] m_axis_tdata  // [2:0] status, [8:3] slot,
	                                                      // [72:9] entry_calls,
	                                                      // [73] became_candidate,
	                                                      // [74] candidate_flag, [79:75] zero
);

	import cpth_pkg::*;

	localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int UW   = $clog2(TABLE_DEPTH + 1);
	localparam int LW   = (UW > LIM_W) ? UW : LIM_W;
	localparam int PW   = CNT_W + UW;
	localparam int CMPW = PW + 1;
	localparam int RW   = CNT_W + 2;

	// sequencer states
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_LOAD   = 3'd3;
	localparam logic [2:0] S_UPD    = 3'd4;
	localparam logic [2:0] S_MUL    = 3'd5;
	localparam logic [2:0] S_RESULT = 3'd6;

	logic [2:0]          state_q;
	logic                kind_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [OPS_W-1:0]    ops_q;
	logic [UW-1:0]       used_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    mem_total_q;
	logic [MINC_W-1:0]   min_calls_q;
	logic [LIM_W-1:0]    entry_limit_q;
	logic [UW-1:0]       scan_q;
	logic                cmp_v_s1;
	logic [IW-1:0]       cmp_idx_s1;
	logic [IW-1:0]       slot_q;
	logic                created_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                mark_q;
	logic [CNT_W-1:0]    memops_q;
	status_t             status_q;
	logic                became_q;
	logic [RW-1:0]       rhs_q;
	logic                out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// table memories
	logic [ADDR_W-1:0] key_mem  [TABLE_DEPTH];
	logic [CNT_W-1:0]  call_mem [TABLE_DEPTH];
	logic [CNT_W-1:0]  ops_mem  [TABLE_DEPTH];
	logic              mark_mem [TABLE_DEPTH];
	logic [ADDR_W-1:0] key_rd_s1;
	logic [CNT_W-1:0]  call_rd_q;
	logic [CNT_W-1:0]  ops_rd_q;
	logic              mark_rd_q;

	logic              accept;
	logic              in_kind;
	logic [ADDR_W-1:0] in_addr;
	logic [OPS_W-1:0]  in_ops;
	logic              scan_more;
	logic              hit;
	logic              miss;
	logic [LW-1:0]     limit;
	logic              full;
	logic              key_we;
	logic              call_we;
	logic              ops_we;
	logic [CNT_W-1:0]  ops_wd;
	logic              mark_we;
	logic              mark_wd;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  total_inc;
	logic              can_test;
	logic              mul_start;
	logic              mul_done;
	logic [PW-1:0]     mul_prod;
	logic [CMPW-1:0]   lhs;
	logic              gt;
	logic              out_free;

	assign in_kind = s_axis_tuser;
	assign in_addr = s_axis_tdata[ADDR_W-1:0];
	assign in_ops  = s_axis_tdata[ADDR_W+OPS_W-1:ADDR_W];

	assign s_axis_tready = (state_q == S_IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// key scan: one read per cycle, compared in the cycle after the read
	assign scan_more = scan_q < used_q;
	assign hit       = cmp_v_s1 && (key_rd_s1 == addr_q);
	assign miss      = !hit && !cmp_v_s1 && !scan_more;

	// an entry_limit above the depth acts as the depth
	assign limit = (LW'(entry_limit_q) > LW'(TABLE_DEPTH)) ? LW'(TABLE_DEPTH)
	                                                       : LW'(entry_limit_q);
	assign full  = LW'(used_q) >= limit;

	assign cnt_inc   = cnt_q + 1'b1;
	assign total_inc = total_q + 1'b1;
	assign can_test  = !mark_q && (total_inc >= CNT_W'(min_calls_q));

	assign key_we  = (state_q == S_SCAN) && miss && !kind_q && !full;
	assign call_we = (state_q == S_UPD) && !kind_q;
	// a new entry starts with zero memory ops and no mark
	assign ops_we  = (state_q == S_UPD) && (kind_q || created_q);
	assign ops_wd  = kind_q ? (memops_q + CNT_W'(ops_q)) : '0;
	assign mark_we = ((state_q == S_UPD) && created_q) ||
	                 ((state_q == S_MUL) && mul_done && gt);
	assign mark_wd = (state_q == S_MUL);

	assign mul_start = (state_q == S_UPD) && !kind_q && can_test;

	// 2*count*entries > 3*total
	assign lhs = {mul_prod, 1'b0};
	assign gt  = lhs > CMPW'(rhs_q);

	assign out_free = !out_valid_q || m_axis_tready;

	cpth_mul #(
		.AW(CNT_W),
		.BW(UW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start),
		.a     (cnt_inc),
		.b     (used_q),
		.done  (mul_done),
		.prod  (mul_prod)
	);

	always_ff @(posedge clk) begin
		if (key_we)
			key_mem[used_q[IW-1:0]] <= addr_q;
		key_rd_s1 <= key_mem[scan_q[IW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (call_we)
			call_mem[slot_q] <= cnt_inc;
		call_rd_q <= call_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (ops_we)
			ops_mem[slot_q] <= ops_wd;
		ops_rd_q <= ops_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		if (mark_we)
			mark_mem[slot_q] <= mark_wd;
		mark_rd_q <= mark_mem[slot_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			kind_q        <= 1'b0;
			addr_q        <= '0;
			ops_q         <= '0;
			used_q        <= '0;
			total_q       <= '0;
			mem_total_q   <= '0;
			min_calls_q   <= MIN_CALLS_RST;
			entry_limit_q <= LIMIT_RST;
			scan_q        <= '0;
			cmp_v_s1      <= 1'b0;
			cmp_idx_s1    <= '0;
			slot_q        <= '0;
			created_q     <= 1'b0;
			cnt_q         <= '0;
			mark_q        <= 1'b0;
			memops_q      <= '0;
			status_q      <= ST_IGNORED;
			became_q      <= 1'b0;
			rhs_q         <= '0;
			out_valid_q   <= 1'b0;
			out_data_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MIN_CALLS:   min_calls_q   <= cfg_data[MINC_W-1:0];
					CFG_ENTRY_LIMIT: entry_limit_q <= cfg_data[LIM_W-1:0];
					default: ;
				endcase
			end

			// raise the result when the sequencer hands it over,
			// drop it once the receiver takes it
			if ((state_q == S_RESULT) && out_free)
				out_valid_q <= 1'b1;
			else if (m_axis_tready)
				out_valid_q <= 1'b0;

			cmp_v_s1 <= (state_q == S_SCAN) && scan_more && !hit;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						kind_q    <= in_kind;
						addr_q    <= in_addr;
						ops_q     <= in_ops;
						created_q <= 1'b0;
						became_q  <= 1'b0;
						scan_q    <= '0;
						if (in_addr == '0 || (in_kind && in_ops == '0)) begin
							status_q <= ST_IGNORED;
							slot_q   <= '0;
							cnt_q    <= '0;
							mark_q   <= 1'b0;
							state_q  <= S_RESULT;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					cmp_idx_s1 <= scan_q[IW-1:0];
					if (scan_more && !hit)
						scan_q <= scan_q + 1'b1;
					if (hit) begin
						slot_q   <= cmp_idx_s1;
						status_q <= ST_EXISTING;
						state_q  <= S_READ;
					end else if (miss) begin
						if (kind_q || full) begin
							status_q <= kind_q ? ST_UNKNOWN : ST_FULL;
							slot_q   <= '0;
							cnt_q    <= '0;
							mark_q   <= 1'b0;
							state_q  <= S_RESULT;
						end else begin
							// append a new entry at the end of the table
							slot_q    <= used_q[IW-1:0];
							used_q    <= used_q + 1'b1;
							created_q <= 1'b1;
							cnt_q     <= '0;
							mark_q    <= 1'b0;
							status_q  <= ST_CREATED;
							state_q   <= S_UPD;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					cnt_q    <= call_rd_q;
					mark_q   <= mark_rd_q;
					memops_q <= ops_rd_q;
					state_q  <= S_UPD;
				end
				S_UPD: begin
					if (kind_q) begin
						mem_total_q <= mem_total_q + CNT_W'(ops_q);
						state_q     <= S_RESULT;
					end else begin
						cnt_q   <= cnt_inc;
						total_q <= total_inc;
						state_q <= can_test ? S_MUL : S_RESULT;
					end
				end
				S_MUL: begin
					rhs_q <= RW'(total_q) + RW'({total_q, 1'b0});
					if (mul_done) begin
						if (gt) begin
							mark_q   <= 1'b1;
							became_q <= 1'b1;
						end
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					// hold until the output register is free
					if (out_free) begin
						out_data_q  <= {5'b0, mark_q, became_q, cnt_q,
						                SLOT_W'(slot_q), status_q};
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// the table never holds more entries than its depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UW'(TABLE_DEPTH))
		else $error("used entry count beyond table depth");

	// the used count only grows, one entry at a time
	a_used_step: assert property (@(posedge clk) disable iff (!arst_n)
		(used_q != $past(used_q)) |-> (used_q == $past(used_q) + 1'b1))
		else $error("used entry count moved by other than one");

	// one request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_axis_tready)
		else $error("request accepted while another is in work");

	// a newly marked candidate reports its mark set
	a_became_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[73]) |-> out_data_q[74])
		else $error("became_candidate without candidate_flag");

endmodule

[tb/call_profile_table_hotspot_unit_test.sv]
// Self-checking testbench for call_profile_table_hotspot_unit: directed and random
// call and memory events, checked against a behavioral table model held here.
// Depends on cpth_pkg and the RTL of the unit; needs no other file.
`timescale 1ns / 100ps

module call_profile_table_hotspot_unit_test;
	import cpth_pkg::*;

	localparam int TABLE_DEPTH    = 64;
	localparam int RANDOM_EVENTS  = 1030;  // random requests, on top of the directed ones
	localparam int SETTLE_CYCLES  = 100;
	localparam int STALL_LIMIT    = 2000;  // cycles with no handshake before giving up

	// event kinds carried on s_axis_tuser
	localparam logic KIND_CALL = 1'b0;
	localparam logic KIND_MEM  = 1'b1;

	// one expected result, fields as they leave on m_axis_tdata
	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic [CNT_W-1:0]    calls;
		logic                became;
		logic                flag;
	} call_result_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	cfg_idx_t               cfg_index = CFG_MIN_CALLS;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata = '0;   // [63:0] func_address, [95:64] op_count
	logic                   s_axis_tuser = 1'b0;  // [0] kind
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;        // [2:0] status, [8:3] slot,
	                                             // [72:9] entry_calls, [73] became_candidate,
	                                             // [74] candidate_flag, [79:75] zero

	call_profile_table_hotspot_unit #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Profile table model: keys, call counts and candidate marks of the
	// entries in use, the running call total and the two registers.
	// ------------------------------------------------------------------
	logic [ADDR_W-1:0] tbl_key   [TABLE_DEPTH];
	logic [CNT_W-1:0]  tbl_calls [TABLE_DEPTH];
	logic              tbl_mark  [TABLE_DEPTH];
	int                tbl_used = 0;
	logic [CNT_W-1:0]  sum_calls = '0;
	logic [MINC_W-1:0] cur_min_calls = MIN_CALLS_RST;
	logic [LIM_W-1:0]  cur_limit = LIMIT_RST;

	call_result_t pending_results[$];  // results owed by the unit, oldest first
	int           fail_count = 0;
	int           burst_left = 0;

	// Apply one event to the table and return the result it must produce.
	function automatic call_result_t profile_event(input logic kind,
			input logic [ADDR_W-1:0] addr, input logic [OPS_W-1:0] ops);
		call_result_t res;
		int hit;
		int limit;
		logic [127:0] lhs;
		logic [127:0] rhs;
		res = '0;
		res.status = ST_IGNORED;
		// zero key, or a memory event that adds nothing: leave the table alone
		if (addr == '0 || (kind == KIND_MEM && ops == '0))
			return res;
		hit = -1;
		for (int i = 0; i < tbl_used; i++) begin
			if (hit < 0 && tbl_key[i] == addr)
				hit = i;
		end
		if (kind == KIND_MEM) begin
			if (hit < 0) begin
				res.status = ST_UNKNOWN;
				return res;
			end
			res.status = ST_EXISTING;
			res.slot   = hit[SLOT_W-1:0];
			res.calls  = tbl_calls[hit];
			res.flag   = tbl_mark[hit];
			return res;
		end
		if (hit < 0) begin
			// a limit above the depth acts as the depth; zero admits nothing
			limit = (int'(cur_limit) > TABLE_DEPTH) ? TABLE_DEPTH : int'(cur_limit);
			if (tbl_used >= limit) begin
				res.status = ST_FULL;
				return res;
			end
			hit = tbl_used;
			tbl_key[hit]   = addr;
			tbl_calls[hit] = '0;
			tbl_mark[hit]  = 1'b0;
			tbl_used++;
			res.status = ST_CREATED;
		end else begin
			res.status = ST_EXISTING;
		end
		tbl_calls[hit] += 1;
		sum_calls += 1;
		// exact test of count > 1.5 * mean, only for entries not yet marked
		if (!tbl_mark[hit] && sum_calls >= CNT_W'(cur_min_calls)) begin
			lhs = 128'(tbl_calls[hit]) * 128'(2 * tbl_used);
			rhs = 128'(sum_calls) * 128'd3;
			if (lhs > rhs) begin
				tbl_mark[hit] = 1'b1;
				res.became = 1'b1;
			end
		end
		res.slot  = hit[SLOT_W-1:0];
		res.calls = tbl_calls[hit];
		res.flag  = tbl_mark[hit];
		return res;
	endfunction

	function automatic logic [ADDR_W-1:0] fresh_key();
		logic [ADDR_W-1:0] k;
		k = {$urandom, $urandom};
		return (k == '0) ? ADDR_W'(1) : k;
	endfunction

	// ------------------------------------------------------------------
	// Request side: bursts of random length, random gaps between them.
	// The valid stays high from one request to the next inside a burst.
	// ------------------------------------------------------------------
	task automatic send_event(input logic kind, input logic [ADDR_W-1:0] addr,
			input logic [OPS_W-1:0] ops);
		call_result_t res;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// mostly short bursts, now and then a long stretch with no gap
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 90)
			                                         : $urandom_range(1, 10);
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ops, addr};
		s_axis_tuser  <= kind;
		do @(posedge clk); while (!s_axis_tready);
		// accepted at this edge: predict now so results queue up in order
		res = profile_event(kind, addr, ops);
		pending_results.push_back(res);
	endtask

	// Drop the valid and wait until the unit has nothing left in flight.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; only called while the unit is idle.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		if (idx == CFG_MIN_CALLS)
			cur_min_calls = val[MINC_W-1:0];
		else
			cur_limit = val[LIM_W-1:0];
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Result side: check every handed-over result and stall on a pattern
	// that switches in turn between open, sparse, long-hold and alternate modes.
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
			input logic [CNT_W-1:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s: expected %0h, got %0h", name, exp_val, act_val);
			fail_count++;
		end
	endtask

	task automatic check_result(input logic [OUT_DATA_W-1:0] word);
		call_result_t exp_res;
		if (pending_results.size() == 0) begin
			$error("result %h arrived with no request outstanding", word);
			fail_count++;
			return;
		end
		exp_res = pending_results.pop_front();
		check_field("status", CNT_W'(exp_res.status), CNT_W'(word[2:0]));
		check_field("slot", CNT_W'(exp_res.slot), CNT_W'(word[8:3]));
		check_field("entry_calls", exp_res.calls, word[72:9]);
		check_field("became_candidate", CNT_W'(exp_res.became), CNT_W'(word[73]));
		check_field("candidate_flag", CNT_W'(exp_res.flag), CNT_W'(word[74]));
	endtask

	int unsigned rx_cycle = 0;
	int unsigned rx_hold = 0;

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_result(m_axis_tdata);
		rx_cycle++;
		if (rx_hold != 0) begin
			rx_hold--;
			m_axis_tready <= 1'b0;
		end else begin
			case (rx_cycle[9:8])
				2'd0: m_axis_tready <= 1'b1;
				2'd1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2'd2: begin
					if ($urandom_range(0, 15) == 0) begin
						rx_hold = $urandom_range(4, 40);
						m_axis_tready <= 1'b0;
					end else begin
						m_axis_tready <= 1'b1;
					end
				end
				default: m_axis_tready <= rx_cycle[0];
			endcase
		end
	end

	// Watchdog: count cycles in which no handshake of any kind happens.
	int unsigned quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_axis_tvalid && s_axis_tready)
				|| (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed tests
	// ------------------------------------------------------------------

	// Limit zero: nothing can be created; zero keys and empty memory
	// events are ignored, memory events for absent keys are unknown.
	task automatic test_empty_table();
		write_reg(CFG_MIN_CALLS, '0);
		write_reg(CFG_ENTRY_LIMIT, '0);
		send_event(KIND_CALL, 64'h0000_0000_0000_1000, 32'd0);
		send_event(KIND_CALL, '0, 32'hFFFF_FFFF);
		send_event(KIND_MEM, 64'h0000_0000_0000_1000, 32'd5);
		send_event(KIND_MEM, '0, 32'd5);
		send_event(KIND_MEM, 64'h0000_0000_0000_1000, 32'd0);
		settle_idle();
	endtask

	// Limit one: a single entry at the top address, a second key hits the
	// full table, memory events reach the known entry with extreme counts.
	task automatic test_single_entry();
		write_reg(CFG_ENTRY_LIMIT, 32'd1);
		send_event(KIND_CALL, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
		send_event(KIND_CALL, 64'h0000_0000_0000_0001, 32'd0);
		send_event(KIND_MEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_event(KIND_MEM, 64'hFFFF_FFFF_FFFF_FFFF, 32'd1);
		send_event(KIND_CALL, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		settle_idle();
	endtask

	// Limit above the depth, small threshold: grow the table, hammer one
	// key until it is marked, then hit it again once marked. Finally raise
	// the threshold to its top so that no test can pass.
	task automatic test_hotspot_marking();
		write_reg(CFG_ENTRY_LIMIT, 32'd127);
		write_reg(CFG_MIN_CALLS, 32'd4);
		send_event(KIND_CALL, 64'h8000_0000_0000_0000, 32'd0);
		send_event(KIND_CALL, 64'h5555_5555_5555_5555, 32'd0);
		send_event(KIND_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		send_event(KIND_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		send_event(KIND_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		send_event(KIND_CALL, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0);
		send_event(KIND_MEM, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_5555);
		settle_idle();
		write_reg(CFG_MIN_CALLS, 32'hFFFF_FFFF);
		send_event(KIND_CALL, 64'h5555_5555_5555_5555, 32'd0);
		send_event(KIND_CALL, 64'h5555_5555_5555_5555, 32'd0);
		settle_idle();
	endtask

	// ------------------------------------------------------------------
	// Random traffic in phases; each phase sets both registers and picks a
	// hot key that takes a large share of the calls so marks keep coming.
	// ------------------------------------------------------------------
	task automatic test_random_traffic();
		int sent;
		int phase;
		int hot;
		int r;
		logic kind;
		logic [ADDR_W-1:0] addr;
		logic [OPS_W-1:0] ops;
		logic [CFG_DATA_W-1:0] min_val;
		logic [CFG_DATA_W-1:0] lim_val;
		sent = 0;
		phase = 0;
		while (sent < RANDOM_EVENTS) begin
			settle_idle();
			case ($urandom_range(0, 9))
				0: min_val = '0;
				1: min_val = 32'hFFFF_FFFF;
				default: min_val = $urandom_range(0, 400);
			endcase
			if (phase == 0)
				lim_val = 32'd64;
			else begin
				case ($urandom_range(0, 9))
					0: lim_val = '0;
					1: lim_val = $urandom_range(65, 127);
					default: lim_val = $urandom_range(1, 64);
				endcase
			end
			write_reg(CFG_MIN_CALLS, min_val);
			write_reg(CFG_ENTRY_LIMIT, lim_val);
			hot = (tbl_used > 0) ? $urandom_range(0, tbl_used - 1) : -1;
			repeat ($urandom_range(60, 140)) begin
				if (sent >= RANDOM_EVENTS)
					break;
				if (hot < 0 && tbl_used > 0)
					hot = tbl_used - 1;
				r = $urandom_range(0, 99);
				ops = $urandom;
				kind = KIND_CALL;
				if (r < 5) begin
					addr = '0;
				end else if (r < 8) begin
					kind = KIND_MEM;
					addr = '0;
				end else if (r < 11) begin
					kind = KIND_MEM;
					addr = (tbl_used > 0) ? tbl_key[$urandom_range(0, tbl_used - 1)]
					                      : fresh_key();
					ops = '0;
				end else if (r < 16) begin
					kind = KIND_MEM;
					addr = fresh_key();
				end else if (r < 31) begin
					kind = KIND_MEM;
					addr = (tbl_used > 0) ? tbl_key[$urandom_range(0, tbl_used - 1)]
					                      : fresh_key();
					if (ops == '0)
						ops = OPS_W'(1);
				end else if (r < 46 || tbl_used == 0) begin
					addr = fresh_key();
				end else if (r < 71) begin
					addr = tbl_key[hot];
				end else begin
					addr = tbl_key[$urandom_range(0, tbl_used - 1)];
				end
				send_event(kind, addr, ops);
				sent++;
			end
			phase++;
		end
		settle_idle();
	endtask

	initial begin
		// hold reset, then release it on a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_table();
		test_single_entry();
		test_hotspot_marking();
		test_random_traffic();

		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/cpth_pkg.sv
rtl/core/cpth_mul.sv
rtl/core/call_profile_table_hotspot_unit.sv
tb/call_profile_table_hotspot_unit_test.sv
